[sv/rhsm_pkg.sv]
`timescale 1ns / 1ps

package rhsm_pkg;

	// Residue width and the prime modulus of the polynomial hash
	localparam int HW = 30;
	localparam logic [HW-1:0] HASH_MOD  = 30'd1000000007;
	localparam logic [HW-1:0] HASH_BASE = 30'd31;
	localparam logic [7:0]    SYMBOL_BIAS = 8'd96;

	localparam int DEF_MAX_PATTERN   = 64;
	localparam int DEF_POSITION_BITS = 20;

	// Input word kinds carried on tuser
	localparam logic [1:0] KIND_PATTERN = 2'd0;
	localparam logic [1:0] KIND_TEXT    = 2'd1;
	localparam logic [1:0] KIND_CLEAR   = 2'd2;

	typedef logic [HW-1:0] hash_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mm_stat_t;

	// (x + y) mod P for x, y below P
	function automatic hash_t addmod(hash_t x, hash_t y);
		logic [HW:0] s;
		s = {1'b0, x} + {1'b0, y};
		if (s >= {1'b0, HASH_MOD})
			s = s - {1'b0, HASH_MOD};
		return s[HW-1:0];
	endfunction

	// (x - y) mod P for x, y below P
	function automatic hash_t submod(hash_t x, hash_t y);
		logic [HW:0] d;
		d = {1'b0, x} - {1'b0, y};
		if (x < y)
			d = d + {1'b0, HASH_MOD};
		return d[HW-1:0];
	endfunction

	// (-r) mod P for r below P
	function automatic hash_t negmod(hash_t r);
		return (r == '0) ? '0 : HASH_MOD - r;
	endfunction

endpackage

[sv/rhsm_ram.sv]
`timescale 1ns / 1ps

module rhsm_ram #(
	parameter int WIDTH = 30,
	parameter int DEPTH = 65
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_data <= mem[rd_addr];
	end

endmodule

[sv/rhsm_mulmod.sv]
`timescale 1ns / 1ps

// Radix-2 modular multiplier, multiplier operand consumed LSB first, one bit a cycle.
module rhsm_mulmod (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  rhsm_pkg::hash_t     a,
	input  rhsm_pkg::hash_t     b,
	output rhsm_pkg::mm_stat_t  stat,
	output rhsm_pkg::hash_t     result
);

	import rhsm_pkg::*;

	hash_t acc_q;
	hash_t a_q;
	hash_t b_q;
	logic  busy_q;
	logic  done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			acc_q  <= '0;
			a_q    <= '0;
			b_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				acc_q  <= '0;
				a_q    <= a;
				b_q    <= b;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (b_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					if (b_q[0])
						acc_q <= addmod(acc_q, a_q);
					a_q <= addmod(a_q, a_q);
					b_q <= b_q >> 1;
				end
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign result    = acc_q;

	a_mm_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (acc_q < HASH_MOD && a_q < HASH_MOD))
		else $error("mulmod residue out of range");

	a_mm_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("mulmod started while busy");

endmodule

[sv/rolling_hash_substring_matcher_unit.sv]
`timescale 1ns / 1ps

// Channel  Dir  Signals                     Contents
// s_       in   tvalid tready tdata tuser   tdata: symbol[7:0]; tuser: kind[1:0]
// m_       out  tvalid tready tdata         tdata: match[0], start_index[PB:1], zero pad
//
// A text word holds s_tready low while up to four modular multiplications run in turn on
// one radix-2 multiplier, each costing more the longer its multiplier operand is;
// pattern_hash x 31^start dominates, and a word whose window is not yet full skips the
// last two. A pattern word runs two of them; an ignored pattern word or a clear leaves
// s_tready high.
// Reset clears all control state; the prefix-hash ring needs no clearing pass, as only
// entries written since the last clear or pattern word are ever used.
// A waiting result does not block input: s_tready rises again once the result is latched.
// A text word whose result finds the previous one still unread holds in its last state.
module rolling_hash_substring_matcher_unit #(
	parameter int MAX_PATTERN   = rhsm_pkg::DEF_MAX_PATTERN,
	parameter int POSITION_BITS = rhsm_pkg::DEF_POSITION_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [7:0]                           s_tdata,  // symbol[7:0]
	input  logic [1:0]                           s_tuser,  // kind[1:0]
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [((POSITION_BITS+8)/8)*8-1:0]   m_tdata   // match[0], start_index above
);

	import rhsm_pkg::*;

	localparam int OTW        = ((POSITION_BITS + 8) / 8) * 8;
	localparam int RING_DEPTH = MAX_PATTERN + 1;
	localparam int RAW        = $clog2(RING_DEPTH);
	localparam int LW         = $clog2(MAX_PATTERN + 1);
	localparam int SW         = (POSITION_BITS > LW) ? POSITION_BITS : LW;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PV,    // pattern: v * 31^k
		ST_PB,    // pattern: advance power
		ST_TV,    // text: v * 31^pos
		ST_TB,    // text: advance power
		ST_TT,    // text: scaled pattern hash
		ST_TW,    // text: advance window start power
		ST_OUT
	} state_t;

	state_t state_q;

	// Pattern state
	hash_t           pat_hash_q;
	hash_t           pat_pow_q;
	logic [LW-1:0]   plen_q;

	// Text state
	logic [POSITION_BITS-1:0] pos_q;
	hash_t           txt_pow_q;
	hash_t           wsp_q;
	hash_t           run_q;
	logic [RAW-1:0]  head_q;
	logic [LW-1:0]   fill_q;

	// Per-word working registers
	logic            neg_q;
	logic            full_q;
	hash_t           window_q;
	logic            match_q;

	// Multiplier request
	logic            mm_start_q;
	hash_t           mm_a_q;
	hash_t           mm_b_q;
	mm_stat_t        mm_stat;
	hash_t           mm_res;

	hash_t           ring_rd;

	logic            neg_in;
	logic [7:0]      mag_in;
	hash_t           term;
	logic [RAW-1:0]  head_nx;
	logic [LW-1:0]   fill_nx;
	logic            full_nx;
	logic [RAW:0]    slot_sum;
	logic [RAW:0]    slot_wrap;
	logic [SW-1:0]   start_wide;
	logic [POSITION_BITS-1:0] start_idx;
	logic            in_acc;

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;

	// Split the symbol into a magnitude and a sign around the bias
	assign neg_in = (s_tdata < SYMBOL_BIAS);
	assign mag_in = neg_in ? (SYMBOL_BIAS - s_tdata) : (s_tdata - SYMBOL_BIAS);

	// Restore the sign of the product
	assign term = neg_q ? negmod(mm_res) : mm_res;

	assign head_nx = (head_q == RAW'(MAX_PATTERN)) ? '0 : head_q + 1'b1;
	assign fill_nx = (fill_q == LW'(MAX_PATTERN)) ? fill_q : fill_q + 1'b1;
	assign full_nx = (plen_q != '0) && (fill_nx >= plen_q);

	// Ring slot holding the prefix hash at the window start
	assign slot_sum  = (RAW+1)'(head_q) + (RAW+1)'(RING_DEPTH + 1) - (RAW+1)'(plen_q);
	assign slot_wrap = (slot_sum >= (RAW+1)'(RING_DEPTH)) ?
		slot_sum - (RAW+1)'(RING_DEPTH) : slot_sum;

	assign start_wide = SW'(pos_q) + SW'(1) - SW'(plen_q);
	assign start_idx  = full_q ? start_wide[POSITION_BITS-1:0] : '0;

	rhsm_ram #(
		.WIDTH (HW),
		.DEPTH (RING_DEPTH)
	) u_ring (
		.clk     (clk),
		.wr_en   (in_acc && (s_tuser == KIND_TEXT)),
		.wr_addr (head_nx),
		.wr_data (run_q),
		.rd_en   (state_q == ST_TV),
		.rd_addr (slot_wrap[RAW-1:0]),
		.rd_data (ring_rd)
	);

	rhsm_mulmod u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mm_start_q),
		.a      (mm_a_q),
		.b      (mm_b_q),
		.stat   (mm_stat),
		.result (mm_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pat_hash_q <= '0;
			pat_pow_q  <= hash_t'(1);
			plen_q     <= '0;
			pos_q      <= '0;
			txt_pow_q  <= hash_t'(1);
			wsp_q      <= hash_t'(1);
			run_q      <= '0;
			head_q     <= '0;
			fill_q     <= '0;
			neg_q      <= 1'b0;
			full_q     <= 1'b0;
			window_q   <= '0;
			match_q    <= 1'b0;
			mm_start_q <= 1'b0;
			mm_a_q     <= '0;
			mm_b_q     <= '0;
			m_tvalid   <= 1'b0;
			m_tdata    <= '0;
		end else begin
			mm_start_q <= 1'b0;
			// Drop the result once taken; the final state reloads the register itself
			if (m_tvalid && m_tready && state_q != ST_OUT)
				m_tvalid <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						neg_q <= neg_in;
						case (s_tuser)
							KIND_CLEAR: begin
								pat_hash_q <= '0;
								pat_pow_q  <= hash_t'(1);
								plen_q     <= '0;
								pos_q      <= '0;
								txt_pow_q  <= hash_t'(1);
								wsp_q      <= hash_t'(1);
								run_q      <= '0;
								head_q     <= '0;
								fill_q     <= '0;
							end
							KIND_PATTERN: begin
								// A pattern word restarts the text
								pos_q     <= '0;
								txt_pow_q <= hash_t'(1);
								wsp_q     <= hash_t'(1);
								run_q     <= '0;
								head_q    <= '0;
								fill_q    <= '0;
								if (plen_q != LW'(MAX_PATTERN)) begin
									mm_a_q     <= pat_pow_q;
									mm_b_q     <= hash_t'(mag_in);
									mm_start_q <= 1'b1;
									state_q    <= ST_PV;
								end
							end
							KIND_TEXT: begin
								head_q     <= head_nx;
								fill_q     <= fill_nx;
								full_q     <= full_nx;
								mm_a_q     <= txt_pow_q;
								mm_b_q     <= hash_t'(mag_in);
								mm_start_q <= 1'b1;
								state_q    <= ST_TV;
							end
							default: ;
						endcase
					end
				end
				ST_PV: begin
					if (mm_stat.done) begin
						pat_hash_q <= addmod(pat_hash_q, term);
						mm_a_q     <= pat_pow_q;
						mm_b_q     <= HASH_BASE;
						mm_start_q <= 1'b1;
						state_q    <= ST_PB;
					end
				end
				ST_PB: begin
					if (mm_stat.done) begin
						pat_pow_q <= mm_res;
						plen_q    <= plen_q + 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				ST_TV: begin
					if (mm_stat.done) begin
						run_q      <= addmod(run_q, term);
						mm_a_q     <= txt_pow_q;
						mm_b_q     <= HASH_BASE;
						mm_start_q <= 1'b1;
						state_q    <= ST_TB;
					end
				end
				ST_TB: begin
					if (mm_stat.done) begin
						txt_pow_q <= mm_res;
						// Window hash: prefix after this symbol less prefix at the start
						window_q  <= submod(run_q, ring_rd);
						if (full_q) begin
							mm_a_q     <= pat_hash_q;
							mm_b_q     <= wsp_q;
							mm_start_q <= 1'b1;
							state_q    <= ST_TT;
						end else begin
							match_q <= 1'b0;
							state_q <= ST_OUT;
						end
					end
				end
				ST_TT: begin
					if (mm_stat.done) begin
						match_q    <= (window_q == mm_res);
						mm_a_q     <= wsp_q;
						mm_b_q     <= HASH_BASE;
						mm_start_q <= 1'b1;
						state_q    <= ST_TW;
					end
				end
				ST_TW: begin
					if (mm_stat.done) begin
						wsp_q   <= mm_res;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					// Hold until the output register is free
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						m_tdata  <= OTW'({start_idx, match_q});
						pos_q    <= pos_q + 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_ring_head: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= RAW'(MAX_PATTERN))
		else $error("ring head beyond depth");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q <= LW'(MAX_PATTERN)) && (plen_q <= LW'(MAX_PATTERN)))
		else $error("fill or pattern length beyond maximum");

	a_compare_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TT || state_q == ST_TW) |-> (full_q && plen_q != '0))
		else $error("window compare without full window");

endmodule
